// ===== hw/rtl/sensor_fault_supervisor_defines.svh =====
// Assertion macros used by the sensor fault supervisor checker.
`ifndef SENSOR_FAULT_SUPERVISOR_DEFINES_SVH
`define SENSOR_FAULT_SUPERVISOR_DEFINES_SVH

// Checked outside reset only.
`define SFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/sfs_pkg.sv =====
// Types, constants and helpers of the sensor fault supervisor.
package sfs_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned TempW   = 16;
  localparam int unsigned HumW    = 16;
  localparam int unsigned PresW   = 18;
  localparam int unsigned CountW  = 8;
  localparam int unsigned RetryW  = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OutageW = 23;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 18;

  // Elapsed ms / 1000 == (elapsed >> 3) * DivMul >> DivShift, exact for 29-bit operands.
  localparam int unsigned DivPreShift = 3;
  localparam int unsigned DivOpW      = TimeW - DivPreShift;
  localparam int unsigned DivMulW     = 30;
  localparam int unsigned DivShift    = 36;
  localparam int unsigned DivProdW    = DivOpW + DivMulW;
  localparam logic [DivMulW-1:0] DivMul = 30'd549755814;

  localparam logic signed [TempW-1:0] TempMinRst   = -16'sd4000;
  localparam logic signed [TempW-1:0] TempMaxRst   = 16'sd8500;
  localparam logic [HumW-1:0]         HumMaxRst    = 16'd10000;
  localparam logic [PresW-1:0]        PresMinRst   = 18'd30000;
  localparam logic [PresW-1:0]        PresMaxRst   = 18'd120000;
  localparam logic [CountW-1:0]       StuckLimRst  = 8'd3;
  localparam logic [RetryW-1:0]       FaultRetryRst = 16'd2000;
  localparam logic [RetryW-1:0]       OffRetryRst  = 16'd3000;

  localparam logic [CountW-1:0] CountMax     = '1;
  localparam logic [CountW-1:0] FailRecovLim = 8'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_MIN    = 3'd0,
    REG_TEMP_MAX    = 3'd1,
    REG_HUM_MAX     = 3'd2,
    REG_PRES_MIN    = 3'd3,
    REG_PRES_MAX    = 3'd4,
    REG_STUCK_LIMIT = 3'd5,
    REG_FAULT_RETRY = 3'd6,
    REG_OFF_RETRY   = 3'd7
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    KIND_NOACK   = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_BOUNDS  = 2'd2,
    KIND_STUCK   = 2'd3
  } fault_kind_e;

  typedef struct packed {
    logic signed [TempW-1:0] temp_min;
    logic signed [TempW-1:0] temp_max;
    logic [HumW-1:0]         hum_max;
    logic [PresW-1:0]        pres_min;
    logic [PresW-1:0]        pres_max;
    logic [CountW-1:0]       stuck_limit;
    logic [RetryW-1:0]       fault_retry_ms;
    logic [RetryW-1:0]       offline_retry_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]        now_ms;
    logic                    ack_ok;
    logic                    reading_invalid;
    logic signed [TempW-1:0] temp_in;
    logic [HumW-1:0]         hum_in;
    logic [PresW-1:0]        pres_in;
    logic                    recovery_ok;
  } item_t;

  typedef struct packed {
    logic                    reading_valid;
    logic signed [TempW-1:0] temp_out;
    logic [HumW-1:0]         hum_out;
    logic [PresW-1:0]        pres_out;
    logic                    fault_event;
    fault_kind_e             fault_kind;
    logic                    recovery_request;
    logic                    recovered_event;
    logic [OutageW-1:0]      outage_seconds;
    logic                    sensor_ready;
    logic [CountW-1:0]       failure_count;
  } res_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountMax) ? CountMax : v + CountW'(1);
  endfunction

endpackage

// ===== hw/rtl/sfs_cfg_regs.sv =====
// Configuration register file of the sensor fault supervisor.
module sfs_cfg_regs import sfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_min         <= TempMinRst;
      cfg_q.temp_max         <= TempMaxRst;
      cfg_q.hum_max          <= HumMaxRst;
      cfg_q.pres_min         <= PresMinRst;
      cfg_q.pres_max         <= PresMaxRst;
      cfg_q.stuck_limit      <= StuckLimRst;
      cfg_q.fault_retry_ms   <= FaultRetryRst;
      cfg_q.offline_retry_ms <= OffRetryRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TEMP_MIN:    cfg_q.temp_min         <= $signed(cfg_wdata_i[TempW-1:0]);
        REG_TEMP_MAX:    cfg_q.temp_max         <= $signed(cfg_wdata_i[TempW-1:0]);
        REG_HUM_MAX:     cfg_q.hum_max          <= cfg_wdata_i[HumW-1:0];
        REG_PRES_MIN:    cfg_q.pres_min         <= cfg_wdata_i[PresW-1:0];
        REG_PRES_MAX:    cfg_q.pres_max         <= cfg_wdata_i[PresW-1:0];
        REG_STUCK_LIMIT: cfg_q.stuck_limit      <= cfg_wdata_i[CountW-1:0];
        REG_FAULT_RETRY: cfg_q.fault_retry_ms   <= cfg_wdata_i[RetryW-1:0];
        REG_OFF_RETRY:   cfg_q.offline_retry_ms <= cfg_wdata_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/sfs_core.sv =====
// Per-poll check, fault tracking and recovery logic with its state registers.
module sfs_core import sfs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic                ready_q, ready_d;
  logic                fault_act_q, fault_act_d;
  logic [TimeW-1:0]    fault_start_q, fault_start_d;
  logic [TimeW-1:0]    last_rec_q, last_rec_d;
  logic [CountW-1:0]   fail_q, fail_d;
  logic [CountW-1:0]   stuck_q, stuck_d;
  logic [TempW-1:0]    last_t_q, last_t_d;
  logic [HumW-1:0]     last_h_q, last_h_d;
  logic [PresW-1:0]    last_p_q, last_p_d;
  fault_kind_e         kind_q, kind_d;

  logic [TimeW-1:0]    rec_elapsed;
  logic [TimeW-1:0]    fault_elapsed;
  logic [DivProdW-1:0] div_prod;
  logic                offline_due, fault_due;
  logic                oob, stuck, failed, do_rec;
  logic                ev, req, recovered, took, valid;
  fault_kind_e         fail_kind;

  assign rec_elapsed   = item_i.now_ms - last_rec_q;
  assign fault_elapsed = item_i.now_ms - fault_start_q;
  assign div_prod      = DivProdW'(fault_elapsed[TimeW-1:DivPreShift]) * DivProdW'(DivMul);
  assign offline_due   = rec_elapsed >= {{(TimeW-RetryW){1'b0}}, cfg_i.offline_retry_ms};
  assign fault_due     = rec_elapsed >= {{(TimeW-RetryW){1'b0}}, cfg_i.fault_retry_ms};

  assign oob = !item_i.reading_invalid &&
               (item_i.pres_in < cfg_i.pres_min || item_i.pres_in > cfg_i.pres_max ||
                item_i.temp_in < cfg_i.temp_min || item_i.temp_in > cfg_i.temp_max ||
                item_i.hum_in > cfg_i.hum_max);

  always_comb begin
    ready_d       = ready_q;
    fault_act_d   = fault_act_q;
    fault_start_d = fault_start_q;
    last_rec_d    = last_rec_q;
    fail_d        = fail_q;
    stuck_d       = stuck_q;
    last_t_d      = last_t_q;
    last_h_d      = last_h_q;
    last_p_d      = last_p_q;
    kind_d        = kind_q;
    ev            = 1'b0;
    req           = 1'b0;
    recovered     = 1'b0;
    took          = 1'b0;
    valid         = 1'b0;
    do_rec        = 1'b0;
    stuck         = 1'b0;
    failed        = 1'b0;
    fail_kind     = KIND_NOACK;

    if (!ready_q) begin
      if (offline_due) begin
        if (!fault_act_d) begin
          fault_act_d   = 1'b1;
          fault_start_d = item_i.now_ms;
          kind_d        = KIND_NOACK;
          ev            = 1'b1;
        end
        do_rec = 1'b1;
      end
    end else if (!item_i.ack_ok) begin
      ready_d = 1'b0;
      fail_d  = sat_inc(fail_q);
      if (!fault_act_d) begin
        fault_act_d   = 1'b1;
        fault_start_d = item_i.now_ms;
        kind_d        = KIND_NOACK;
        ev            = 1'b1;
      end
      do_rec = fault_due;
    end else begin
      took = 1'b1;
      if (!item_i.reading_invalid && !oob) begin
        if (item_i.temp_in == last_t_q && item_i.hum_in == last_h_q &&
            item_i.pres_in == last_p_q) begin
          stuck_d = sat_inc(stuck_q);
          stuck   = stuck_d >= cfg_i.stuck_limit;
        end else begin
          last_t_d = item_i.temp_in;
          last_h_d = item_i.hum_in;
          last_p_d = item_i.pres_in;
          stuck_d  = '0;
        end
      end
      failed = item_i.reading_invalid || oob || stuck;
      if (item_i.reading_invalid) begin
        fail_kind = KIND_INVALID;
      end else if (oob) begin
        fail_kind = KIND_BOUNDS;
      end else begin
        fail_kind = KIND_STUCK;
      end
      if (failed) begin
        fail_d = sat_inc(fail_q);
        if (!fault_act_d) begin
          fault_act_d   = 1'b1;
          fault_start_d = item_i.now_ms;
          kind_d        = fail_kind;
          ev            = 1'b1;
        end
        do_rec = (fail_d >= FailRecovLim || stuck) && fault_due;
      end else begin
        if (fault_act_q) begin
          fault_act_d = 1'b0;
          recovered   = 1'b1;
        end
        fail_d = '0;
        valid  = 1'b1;
      end
    end

    if (do_rec) begin
      last_rec_d = item_i.now_ms;
      req        = 1'b1;
      if (item_i.recovery_ok) begin
        ready_d = 1'b1;
        fail_d  = '0;
        stuck_d = '0;
      end else begin
        ready_d = 1'b0;
        if (!fault_act_d) begin
          fault_act_d   = 1'b1;
          fault_start_d = item_i.now_ms;
          kind_d        = KIND_NOACK;
        end
        ev = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q       <= 1'b1;
      fault_act_q   <= 1'b0;
      fault_start_q <= '0;
      last_rec_q    <= '0;
      fail_q        <= '0;
      stuck_q       <= '0;
      last_t_q      <= '0;
      last_h_q      <= '0;
      last_p_q      <= '0;
      kind_q        <= KIND_NOACK;
    end else if (step_i) begin
      ready_q       <= ready_d;
      fault_act_q   <= fault_act_d;
      fault_start_q <= fault_start_d;
      last_rec_q    <= last_rec_d;
      fail_q        <= fail_d;
      stuck_q       <= stuck_d;
      last_t_q      <= last_t_d;
      last_h_q      <= last_h_d;
      last_p_q      <= last_p_d;
      kind_q        <= kind_d;
    end
  end

  always_comb begin
    res_o.reading_valid    = valid;
    res_o.temp_out         = took ? item_i.temp_in : '0;
    res_o.hum_out          = took ? item_i.hum_in : '0;
    res_o.pres_out         = took ? item_i.pres_in : '0;
    res_o.fault_event      = ev;
    res_o.fault_kind       = kind_d;
    res_o.recovery_request = req;
    res_o.recovered_event  = recovered;
    res_o.outage_seconds   = recovered ? div_prod[DivShift +: OutageW] : '0;
    res_o.sensor_ready     = ready_d;
    res_o.failure_count    = fail_d;
  end

endmodule

// ===== hw/rtl/sensor_fault_supervisor.sv =====
// Top level of the sensor fault supervisor: input register, core and result register.
// An accepted poll is held in the input register, its result in the result register.
// Throughput: one poll per cycle; with the result stalled, one more poll enters the
// input register and then the input stalls until the result beat is taken.
// Reset (rst_ni low, asynchronous) empties both registers and restores the
// configuration and supervisor state to their defaults.
module sensor_fault_supervisor import sfs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TimeW-1:0]        now_ms_i,
  input  logic                    ack_ok_i,
  input  logic                    reading_invalid_i,
  input  logic signed [TempW-1:0] temp_in_i,
  input  logic [HumW-1:0]         hum_in_i,
  input  logic [PresW-1:0]        pres_in_i,
  input  logic                    recovery_ok_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    reading_valid_o,
  output logic signed [TempW-1:0] temp_out_o,
  output logic [HumW-1:0]         hum_out_o,
  output logic [PresW-1:0]        pres_out_o,
  output logic                    fault_event_o,
  output logic [KindW-1:0]        fault_kind_o,
  output logic                    recovery_request_o,
  output logic                    recovered_event_o,
  output logic [OutageW-1:0]      outage_seconds_o,
  output logic                    sensor_ready_o,
  output logic [CountW-1:0]       failure_count_o
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_valid_q, out_valid_q;
  logic  advance, step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  sfs_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.now_ms          <= now_ms_i;
      item_q.ack_ok          <= ack_ok_i;
      item_q.reading_invalid <= reading_invalid_i;
      item_q.temp_in         <= temp_in_i;
      item_q.hum_in          <= hum_in_i;
      item_q.pres_in         <= pres_in_i;
      item_q.recovery_ok     <= recovery_ok_i;
    end
  end

  sfs_core u_core (
    .clk_i,
    .rst_ni,
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign reading_valid_o    = res_q.reading_valid;
  assign temp_out_o         = res_q.temp_out;
  assign hum_out_o          = res_q.hum_out;
  assign pres_out_o         = res_q.pres_out;
  assign fault_event_o      = res_q.fault_event;
  assign fault_kind_o       = res_q.fault_kind;
  assign recovery_request_o = res_q.recovery_request;
  assign recovered_event_o  = res_q.recovered_event;
  assign outage_seconds_o   = res_q.outage_seconds;
  assign sensor_ready_o     = res_q.sensor_ready;
  assign failure_count_o    = res_q.failure_count;

endmodule

// ===== hw/rtl/sfs_checker.sv =====
// Port-level assertions of the sensor fault supervisor and their bind.
`include "sensor_fault_supervisor_defines.svh"

module sfs_checker import sfs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               reading_valid_o,
  input logic               fault_event_o,
  input logic               recovery_request_o,
  input logic               recovered_event_o,
  input logic [OutageW-1:0] outage_seconds_o,
  input logic               sensor_ready_o,
  input logic [CountW-1:0]  failure_count_o
);

  `SFS_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !out_valid_o, "result beat during reset")
  `SFS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped")
  `SFS_ASSERT(a_valid_clean,
              out_valid_o && reading_valid_o |->
              !fault_event_o && !recovery_request_o && failure_count_o == '0 && sensor_ready_o,
              "good reading with fault or recovery")
  `SFS_ASSERT(a_outage_only_on_recover,
              out_valid_o && (outage_seconds_o != '0 || recovered_event_o) |->
              recovered_event_o && reading_valid_o,
              "outage reported without a recovered good reading")

endmodule

bind sensor_fault_supervisor sfs_checker u_sfs_checker (.*);

// ===== dv/tb_sensor_fault_supervisor.sv =====
// Self-checking testbench of the sensor fault supervisor with a built-in poll predictor.
module tb_sensor_fault_supervisor;
  timeunit 1ns;
  timeprecision 1ps;
  import sfs_pkg::*;

  localparam int RandPolls = 165;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    item_t poll;
    logic  has_want;
    res_t  want;
  } poll_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  cfg_reg_e                cfg_idx_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [TimeW-1:0]        now_ms_i;
  logic                    ack_ok_i;
  logic                    reading_invalid_i;
  logic signed [TempW-1:0] temp_in_i;
  logic [HumW-1:0]         hum_in_i;
  logic [PresW-1:0]        pres_in_i;
  logic                    recovery_ok_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    reading_valid_o;
  logic signed [TempW-1:0] temp_out_o;
  logic [HumW-1:0]         hum_out_o;
  logic [PresW-1:0]        pres_out_o;
  logic                    fault_event_o;
  logic [KindW-1:0]        fault_kind_o;
  logic                    recovery_request_o;
  logic                    recovered_event_o;
  logic [OutageW-1:0]      outage_seconds_o;
  logic                    sensor_ready_o;
  logic [CountW-1:0]       failure_count_o;

  sensor_fault_supervisor uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .now_ms_i,
    .ack_ok_i,
    .reading_invalid_i,
    .temp_in_i,
    .hum_in_i,
    .pres_in_i,
    .recovery_ok_i,
    .out_valid_o,
    .out_ready_i,
    .reading_valid_o,
    .temp_out_o,
    .hum_out_o,
    .pres_out_o,
    .fault_event_o,
    .fault_kind_o,
    .recovery_request_o,
    .recovered_event_o,
    .outage_seconds_o,
    .sensor_ready_o,
    .failure_count_o
  );

  // Supervisor mirror: limits and state
  cfg_t                    limits;
  logic                    sv_ready;
  logic                    sv_fault;
  logic [TimeW-1:0]        sv_fault_start;
  logic [TimeW-1:0]        sv_last_rec;
  logic [CountW-1:0]       sv_fail;
  logic [CountW-1:0]       sv_attempts;
  logic [CountW-1:0]       sv_stuck;
  logic signed [TempW-1:0] sv_last_temp;
  logic [HumW-1:0]         sv_last_hum;
  logic [PresW-1:0]        sv_last_pres;
  fault_kind_e             sv_kind;

  res_t pending_reports[$];

  int unsigned mismatches;
  int unsigned polls_sent;
  int unsigned reports_checked;
  int unsigned recovery_reqs;
  int unsigned recovered_seen;
  int unsigned fault_events;
  int unsigned settings_used;
  int unsigned idle_cycles;
  int          send_burst;
  int          stuck_run;
  logic        hold_off;

  logic [TimeW-1:0]        sim_ms;
  logic signed [TempW-1:0] held_temp;
  logic [HumW-1:0]         held_hum;
  logic [PresW-1:0]        held_pres;

  poll_row_t poll_table [23] = '{
    '{'{32'd100, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b0}, 1'b1,
      '{1'b1, 16'sd2500, 16'd5000, 18'd101325, 1'b0, KIND_NOACK, 1'b0, 1'b0,
        23'd0, 1'b1, 8'd0}},
    '{'{32'd200, 1'b1, 1'b1, 16'sd2500, 16'd5000, 18'd101325, 1'b0}, 1'b1,
      '{1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1, KIND_INVALID, 1'b0, 1'b0,
        23'd0, 1'b1, 8'd1}},
    '{'{32'd1200, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b0}, 1'b1,
      '{1'b1, 16'sd2500, 16'd5000, 18'd101325, 1'b0, KIND_INVALID, 1'b0, 1'b1,
        23'd1, 1'b1, 8'd0}},
    '{'{32'd1300, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b0}, 1'b0, '0},
    '{'{32'd1400, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b0}, 1'b0, '0},
    '{'{32'd2500, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1}, 1'b0, '0},
    '{'{32'd2600, 1'b1, 1'b0, 16'sh8000, 16'd5000, 18'd101325, 1'b0}, 1'b0, '0},
    '{'{32'd2700, 1'b1, 1'b0, 16'sh7FFF, 16'd5000, 18'd101325, 1'b0}, 1'b0, '0},
    '{'{32'd2800, 1'b1, 1'b0, -16'sd4000, 16'd0, 18'd30000, 1'b0}, 1'b0, '0},
    '{'{32'd2900, 1'b1, 1'b0, 16'sd8500, 16'd10000, 18'd120000, 1'b0}, 1'b0, '0},
    '{'{32'd3000, 1'b1, 1'b0, 16'sd2500, 16'hFFFF, 18'd101325, 1'b0}, 1'b0, '0},
    '{'{32'd3100, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd0, 1'b0}, 1'b0, '0},
    '{'{32'd5000, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'h3FFFF, 1'b0}, 1'b0, '0},
    '{'{32'd5100, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1}, 1'b0, '0},
    '{'{32'd8000, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b0}, 1'b0, '0},
    '{'{32'd11000, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1}, 1'b0, '0},
    '{'{32'd11100, 1'b0, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1}, 1'b0, '0},
    '{'{32'd14100, 1'b1, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1}, 1'b0, '0},
    '{'{32'd20000, 1'b0, 1'b0, 16'sd2500, 16'd5000, 18'd101325, 1'b1}, 1'b0, '0},
    '{'{32'd25000, 1'b1, 1'b0, -16'sd1, 16'd1, 18'd50000, 1'b0}, 1'b0, '0},
    '{'{32'hFFFF_FC18, 1'b1, 1'b1, -16'sd1, 16'hFFFF, 18'h3FFFF, 1'b0}, 1'b0, '0},
    '{'{32'h0000_03E8, 1'b1, 1'b0, 16'sd100, 16'd4000, 18'd100000, 1'b0}, 1'b0, '0},
    '{'{32'h0000_0500, 1'b0, 1'b1, 16'sd100, 16'd4000, 18'd100000, 1'b0}, 1'b0, '0}
  };

  cfg_t phase_cfg [4] = '{
    '{-16'sd100, 16'sd100, 16'd2000, 18'd90000, 18'd110000, 8'd1, 16'd0, 16'd0},
    '{16'sh8000, 16'sh7FFF, 16'hFFFF, 18'd0, 18'h3FFFF, 8'hFF, 16'hFFFF, 16'hFFFF},
    '{16'sd0, 16'sd0, 16'd0, 18'h3FFFF, 18'h3FFFF, 8'd0, 16'd1, 16'd1},
    '{-16'sd4000, 16'sd8500, 16'd10000, 18'd30000, 18'd120000, 8'd2, 16'd500, 16'd800}
  };

  function automatic logic [CountW-1:0] sat_bump(input logic [CountW-1:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic void open_fault(input logic [TimeW-1:0] now, input fault_kind_e kind,
                                     inout logic ev);
    if (!sv_fault) begin
      sv_fault = 1'b1;
      sv_fault_start = now;
      sv_kind = kind;
      ev = 1'b1;
    end
  endfunction

  function automatic void run_recovery(input logic [TimeW-1:0] now, input logic ok,
                                       inout logic ev);
    sv_last_rec = now;
    sv_attempts = sat_bump(sv_attempts);
    if (ok) begin
      sv_ready = 1'b1;
      sv_fail = '0;
      sv_stuck = '0;
      sv_attempts = '0;
    end else begin
      sv_ready = 1'b0;
      open_fault(now, KIND_NOACK, ev);
      ev = 1'b1;
    end
  endfunction

  function automatic res_t supervise_poll(input item_t p);
    res_t             r;
    logic             ev;
    logic             req;
    logic             took;
    logic             good;
    logic             oob;
    logic             stuck;
    logic             recovered;
    logic [TimeW-1:0] since_rec;
    logic [TimeW-1:0] outage;
    fault_kind_e      kind;
    r = '0;
    ev = 1'b0;
    req = 1'b0;
    took = 1'b0;
    good = 1'b0;
    oob = 1'b0;
    stuck = 1'b0;
    recovered = 1'b0;
    outage = '0;
    since_rec = p.now_ms - sv_last_rec;
    if (!sv_ready) begin
      if (since_rec >= {16'd0, limits.offline_retry_ms}) begin
        open_fault(p.now_ms, KIND_NOACK, ev);
        req = 1'b1;
        run_recovery(p.now_ms, p.recovery_ok, ev);
      end
    end else if (!p.ack_ok) begin
      sv_ready = 1'b0;
      sv_fail = sat_bump(sv_fail);
      open_fault(p.now_ms, KIND_NOACK, ev);
      if (since_rec >= {16'd0, limits.fault_retry_ms}) begin
        req = 1'b1;
        run_recovery(p.now_ms, p.recovery_ok, ev);
      end
    end else begin
      took = 1'b1;
      oob = !p.reading_invalid &&
            (p.pres_in < limits.pres_min || p.pres_in > limits.pres_max ||
             p.temp_in < limits.temp_min || p.temp_in > limits.temp_max ||
             p.hum_in > limits.hum_max);
      if (!p.reading_invalid && !oob) begin
        if (p.temp_in == sv_last_temp && p.hum_in == sv_last_hum &&
            p.pres_in == sv_last_pres) begin
          sv_stuck = sat_bump(sv_stuck);
          stuck = (sv_stuck >= limits.stuck_limit);
        end else begin
          sv_last_temp = p.temp_in;
          sv_last_hum = p.hum_in;
          sv_last_pres = p.pres_in;
          sv_stuck = '0;
        end
      end
      if (p.reading_invalid || oob || stuck) begin
        if (p.reading_invalid) begin
          kind = KIND_INVALID;
        end else if (oob) begin
          kind = KIND_BOUNDS;
        end else begin
          kind = KIND_STUCK;
        end
        sv_fail = sat_bump(sv_fail);
        open_fault(p.now_ms, kind, ev);
        if ((sv_fail >= 8'd2 || stuck) && since_rec >= {16'd0, limits.fault_retry_ms}) begin
          req = 1'b1;
          run_recovery(p.now_ms, p.recovery_ok, ev);
        end
      end else begin
        if (sv_fault) begin
          outage = (p.now_ms - sv_fault_start) / 32'd1000;
          sv_fault = 1'b0;
          recovered = 1'b1;
        end
        sv_fail = '0;
        good = 1'b1;
      end
    end
    r.reading_valid = good;
    r.temp_out = took ? p.temp_in : '0;
    r.hum_out = took ? p.hum_in : '0;
    r.pres_out = took ? p.pres_in : '0;
    r.fault_event = ev;
    r.fault_kind = sv_kind;
    r.recovery_request = req;
    r.recovered_event = recovered;
    r.outage_seconds = outage[OutageW-1:0];
    r.sensor_ready = sv_ready;
    r.failure_count = sv_fail;
    return r;
  endfunction

  function automatic item_t random_poll();
    item_t p;
    int    mode;
    int    lo;
    int    hi;
    mode = $urandom_range(99, 0);
    if (mode < 3) begin
      sim_ms = $urandom();
    end else if (mode < 5) begin
      sim_ms = 32'hFFFF_FFFF - $urandom_range(3000, 0);
    end else begin
      sim_ms = sim_ms + $urandom_range(1200, 0);
    end
    p.now_ms = sim_ms;
    p.ack_ok = ($urandom_range(9, 0) != 0);
    p.reading_invalid = ($urandom_range(11, 0) == 0);
    p.recovery_ok = 1'($urandom_range(1, 0));
    if (stuck_run > 0) begin
      stuck_run--;
    end else begin
      mode = $urandom_range(99, 0);
      if (mode < 12) begin
        stuck_run = $urandom_range(6, 1);
      end
      if (mode < 80) begin
        lo = int'(limits.temp_min);
        hi = int'(limits.temp_max);
        if (lo <= hi) begin
          held_temp = 16'(lo + int'($urandom_range(hi - lo, 0)));
        end else begin
          held_temp = 16'($urandom());
        end
        held_hum = 16'($urandom_range(limits.hum_max, 0));
        if (limits.pres_min <= limits.pres_max) begin
          held_pres = 18'($urandom_range(limits.pres_max, limits.pres_min));
        end else begin
          held_pres = 18'($urandom());
        end
      end else if (mode < 90) begin
        held_temp = ($urandom_range(1, 0) ? limits.temp_min : limits.temp_max) +
                    16'($urandom_range(2, 0)) - 16'd1;
        held_hum = limits.hum_max + 16'($urandom_range(1, 0));
        held_pres = ($urandom_range(1, 0) ? limits.pres_min : limits.pres_max) +
                    18'($urandom_range(2, 0)) - 18'd1;
      end else begin
        held_temp = 16'($urandom());
        held_hum = 16'($urandom());
        held_pres = 18'($urandom());
      end
    end
    p.temp_in = held_temp;
    p.hum_in = held_hum;
    p.pres_in = held_pres;
    return p;
  endfunction

  function automatic int idle_gap();
    int r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 3) begin
      send_burst = $urandom_range(60, 20);
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_poll(input item_t p, input logic has_want, input res_t want);
    int   gap;
    res_t predicted;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i <= p.now_ms;
    ack_ok_i <= p.ack_ok;
    reading_invalid_i <= p.reading_invalid;
    temp_in_i <= p.temp_in;
    hum_in_i <= p.hum_in;
    pres_in_i <= p.pres_in;
    recovery_ok_i <= p.recovery_ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = supervise_poll(p);
    pending_reports.push_back(has_want ? want : predicted);
    polls_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    logic [CfgDataW-1:0] data;
    for (int k = 0; k < 8; k++) begin
      case (cfg_reg_e'(k))
        REG_TEMP_MIN:    data = {2'b0, s.temp_min};
        REG_TEMP_MAX:    data = {2'b0, s.temp_max};
        REG_HUM_MAX:     data = {2'b0, s.hum_max};
        REG_PRES_MIN:    data = s.pres_min;
        REG_PRES_MAX:    data = s.pres_max;
        REG_STUCK_LIMIT: data = {10'b0, s.stuck_limit};
        REG_FAULT_RETRY: data = {2'b0, s.fault_retry_ms};
        default:         data = {2'b0, s.offline_retry_ms};
      endcase
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(k);
      cfg_wdata_i <= data;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
    end
    limits = s;
    settings_used++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int run_len;
    int stall_len;
    int r;
    out_ready_i = 1'b0;
    forever begin
      run_len = $urandom_range(40, 1);
      r = $urandom_range(99, 0);
      if (r < 60) begin
        stall_len = 0;
      end else if (r < 92) begin
        stall_len = $urandom_range(3, 1);
      end else begin
        stall_len = $urandom_range(40, 10);
      end
      repeat (run_len) begin
        @(negedge clk_i);
        out_ready_i <= !hold_off;
      end
      repeat (stall_len) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Stall the result side long enough to back up the input
  initial begin
    hold_off = 1'b0;
    while (polls_sent < 300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_sensor_fault_supervisor failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : report_check
    res_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_checked++;
      recovery_reqs += recovery_request_o;
      recovered_seen += recovered_event_o;
      fault_events += fault_event_o;
      if (pending_reports.size() == 0) begin
        $error("report beat with no poll pending");
        mismatches++;
      end else begin
        w = pending_reports.pop_front();
        check_field("reading_valid", w.reading_valid, reading_valid_o);
        check_field("temp_out", w.temp_out, temp_out_o);
        check_field("hum_out", w.hum_out, hum_out_o);
        check_field("pres_out", w.pres_out, pres_out_o);
        check_field("fault_event", w.fault_event, fault_event_o);
        check_field("fault_kind", w.fault_kind, fault_kind_o);
        check_field("recovery_request", w.recovery_request, recovery_request_o);
        check_field("recovered_event", w.recovered_event, recovered_event_o);
        check_field("outage_seconds", w.outage_seconds, outage_seconds_o);
        check_field("sensor_ready", w.sensor_ready, sensor_ready_o);
        check_field("failure_count", w.failure_count, failure_count_o);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TEMP_MIN;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    now_ms_i = '0;
    ack_ok_i = 1'b0;
    reading_invalid_i = 1'b0;
    temp_in_i = '0;
    hum_in_i = '0;
    pres_in_i = '0;
    recovery_ok_i = 1'b0;
    mismatches = 0;
    polls_sent = 0;
    reports_checked = 0;
    recovery_reqs = 0;
    recovered_seen = 0;
    fault_events = 0;
    settings_used = 1;
    idle_cycles = 0;
    send_burst = 0;
    stuck_run = 0;
    sim_ms = 32'd30000;
    held_temp = 16'sd2000;
    held_hum = 16'd4000;
    held_pres = 18'd100000;
    limits = '{TempMinRst, TempMaxRst, HumMaxRst, PresMinRst, PresMaxRst, StuckLimRst,
               FaultRetryRst, OffRetryRst};
    sv_ready = 1'b1;
    sv_fault = 1'b0;
    sv_fault_start = '0;
    sv_last_rec = '0;
    sv_fail = '0;
    sv_attempts = '0;
    sv_stuck = '0;
    sv_last_temp = '0;
    sv_last_hum = '0;
    sv_last_pres = '0;
    sv_kind = KIND_NOACK;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (poll_table[i]) begin
      send_poll(poll_table[i].poll, poll_table[i].has_want, poll_table[i].want);
    end
    for (int ph = 0; ph <= 4; ph++) begin
      if (ph > 0) begin
        drain();
        load_settings(phase_cfg[ph-1]);
      end
      repeat (RandPolls) send_poll(random_poll(), 1'b0, '0);
    end
    drain();
    repeat (4) @(posedge clk_i);

    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      mismatches += pending_reports.size();
    end
    $display("checked %0d reports from %0d polls under %0d register settings",
             reports_checked, polls_sent, settings_used);
    $display("saw %0d fault events, %0d recovery requests, %0d recovered events",
             fault_events, recovery_reqs, recovered_seen);
    if (mismatches == 0) begin
      $display("tb_sensor_fault_supervisor passed");
    end else begin
      $display("tb_sensor_fault_supervisor failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_cfg_regs.sv
hw/rtl/sfs_core.sv
hw/rtl/sensor_fault_supervisor.sv
hw/rtl/sfs_checker.sv
dv/tb_sensor_fault_supervisor.sv
